@@ rtl/kalman_lowpass_smoother_top_defines.svh @@
`ifndef KALMAN_LOWPASS_SMOOTHER_TOP_DEFINES_SVH
`define KALMAN_LOWPASS_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define KLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define KLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kls_pkg.sv @@
package kls_pkg;

    localparam int KLS_SAMPLE_BITS   = 16;
    localparam int KLS_FRACTION_BITS = 16;

    localparam int COV_W      = 32;
    localparam int GAIN_W     = COV_W + 1;
    localparam int ALPHA_W    = 17;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // gain/covariance products shift by 32, alpha products by 16
    localparam int GAIN_SH  = COV_W;
    localparam int ALPHA_SH = ALPHA_W - 1;

    // shared multiplier takes the wide operand in a low and a high slice
    localparam int MUL_LO_W = 16;
    localparam int MUL_HI_W = GAIN_W - MUL_LO_W;

    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << COV_W;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_SH;

    localparam logic [COV_W-1:0]   Q_RST        = 32'd300648;
    localparam logic [COV_W-1:0]   R_RST        = 32'd1288490;
    localparam logic [COV_W-1:0]   INIT_COV_RST = 32'd85899346;
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 17'd42819;
    localparam logic               BYPASS_RST   = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROCESS_NOISE         = 3'd0,
        CFG_MEASUREMENT_NOISE     = 3'd1,
        CFG_INITIAL_COVARIANCE    = 3'd2,
        CFG_SMOOTHING_COEFFICIENT = 3'd3,
        CFG_BYPASS                = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_GAIN,
        DP_MUL_E_LO,
        DP_MUL_E_HI,
        DP_UPD_E,
        DP_MUL_P_LO,
        DP_MUL_P_HI,
        DP_UPD_P,
        DP_DIFF_Y,
        DP_MUL_Y_LO,
        DP_MUL_Y_HI,
        DP_UPD_Y
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

    typedef struct packed {
        logic [COV_W-1:0]   q;
        logic [COV_W-1:0]   r;
        logic [ALPHA_W-1:0] alpha;
        logic               bypass;
    } t_cfg;

    typedef struct packed {
        logic             clear;
        logic [COV_W-1:0] init;
    } t_clr;

endpackage

@@ rtl/kls_ctrl.sv @@
`include "kalman_lowpass_smoother_top_defines.svh"

module kls_ctrl
    import kls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  logic  i_bypass,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_GAIN,
        S_ME_LO,
        S_ME_HI,
        S_UPD_E,
        S_MP_LO,
        S_MP_HI,
        S_UPD_P,
        S_DIFF_Y,
        S_MY_LO,
        S_MY_HI,
        S_UPD_Y,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = DP_NOP;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = DP_CAPTURE;
                    n_state  = i_bypass ? S_DONE : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op = DP_DIV_INIT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.op = DP_GAIN;
                n_state  = S_ME_LO;
            end
            S_ME_LO: begin
                o_cmd.op = DP_MUL_E_LO;
                n_state  = S_ME_HI;
            end
            S_ME_HI: begin
                o_cmd.op = DP_MUL_E_HI;
                n_state  = S_UPD_E;
            end
            S_UPD_E: begin
                o_cmd.op = DP_UPD_E;
                n_state  = S_MP_LO;
            end
            S_MP_LO: begin
                o_cmd.op = DP_MUL_P_LO;
                n_state  = S_MP_HI;
            end
            S_MP_HI: begin
                o_cmd.op = DP_MUL_P_HI;
                n_state  = S_UPD_P;
            end
            S_UPD_P: begin
                o_cmd.op = DP_UPD_P;
                n_state  = S_DIFF_Y;
            end
            S_DIFF_Y: begin
                o_cmd.op = DP_DIFF_Y;
                n_state  = S_MY_LO;
            end
            S_MY_LO: begin
                o_cmd.op = DP_MUL_Y_LO;
                n_state  = S_MY_HI;
            end
            S_MY_HI: begin
                o_cmd.op = DP_MUL_Y_HI;
                n_state  = S_UPD_Y;
            end
            S_UPD_Y: begin
                o_cmd.op = DP_UPD_Y;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `KLS_ASSERT_NEXT(a_div_exit, r_state == S_DIV && i_stat.div_last, r_state == S_GAIN, "divider did not hand over after its last step")
    `KLS_ASSERT_NEXT(a_bypass_path, r_state == S_IDLE && i_in_valid && i_bypass, r_state == S_DONE, "bypass transaction entered the filter sequence")
    `KLS_ASSERT_NEXT(a_done_exit, r_state == S_DONE && o_cmd.out_load, r_state == S_IDLE && r_out_valid, "result load did not present a transaction")

endmodule

@@ rtl/kls_dp.sv @@
`include "kalman_lowpass_smoother_top_defines.svh"

module kls_dp
    import kls_pkg::*;
#(
    parameter int SAMPLE_BITS   = KLS_SAMPLE_BITS,
    parameter int FRACTION_BITS = KLS_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  t_cfg                          i_cfg,
    input  t_clr                          i_clr,
    input  logic signed [SAMPLE_BITS-1:0] i_raw_sample,
    output logic signed [SAMPLE_BITS-1:0] o_kalman_value,
    output logic signed [SAMPLE_BITS-1:0] o_smoothed_value
);

    localparam int EW    = SAMPLE_BITS + FRACTION_BITS;
    localparam int MW    = EW + 1;
    localparam int AW    = (MW > COV_W) ? MW : COV_W;
    localparam int PW    = AW + MUL_HI_W;
    localparam int ACC_W = AW + GAIN_W;
    localparam int OW    = SAMPLE_BITS + 1;
    localparam int RW    = COV_W + 2;

    localparam logic [MW-1:0] ROUND_HALF = MW'(1) << (FRACTION_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // filter state
    logic [EW-1:0]    r_est;
    logic [EW-1:0]    r_y;
    logic [COV_W-1:0] r_p;
    logic [CNT_W-1:0] r_cnt;

    // per-transaction working registers
    logic [SAMPLE_BITS-1:0] r_raw;
    logic [COV_W-1:0]       r_pp;
    logic [COV_W:0]         r_den;
    logic [RW-1:0]          r_rem;
    logic [GAIN_W-1:0]      r_q;
    logic [GAIN_W-1:0]      r_gain;
    logic [GAIN_W-1:0]      r_cgain;
    logic [MW-1:0]          r_mag;
    logic                   r_neg;
    logic [ACC_W-1:0]       r_acc;
    logic signed [SAMPLE_BITS-1:0] r_kal;
    logic signed [SAMPLE_BITS-1:0] r_smo;

    logic [EW-1:0]     x;
    logic [COV_W:0]    pp_sum;
    logic [COV_W-1:0]  pp_sat;
    logic [RW-1:0]     div_t;
    logic [RW-1:0]     div_sub;
    logic              div_ge;
    logic [EW-1:0]     diff_tgt;
    logic [EW-1:0]     diff_base;
    logic [MW-1:0]     diff;
    logic              diff_neg;
    logic [MW-1:0]     diff_mag;
    logic [AW-1:0]     mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic              mul_hi;
    logic [MUL_HI_W-1:0] b_part;
    logic [PW-1:0]     prod;
    logic [MW-1:0]     step_e;
    logic [MW-1:0]     step_y;
    logic [MW-1:0]     est_sum;
    logic [MW-1:0]     y_sum;
    logic [COV_W-1:0]  p_next;

    function automatic logic [SAMPLE_BITS-1:0] f_round_sat(input logic [EW-1:0] v);
        logic [MW-1:0]          t;
        logic [OW-1:0]          r;
        logic [SAMPLE_BITS-1:0] res;
        t = {v[EW-1], v} + ROUND_HALF;
        r = t[MW-1:FRACTION_BITS];
        if (r[OW-1] != r[OW-2]) begin
            res = r[OW-1] ? SAT_MIN : SAT_MAX;
        end else begin
            res = r[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    assign x = {r_raw, {FRACTION_BITS{1'b0}}};

    assign pp_sum = {1'b0, r_p} + {1'b0, i_cfg.q};
    assign pp_sat = pp_sum[COV_W] ? {COV_W{1'b1}} : pp_sum[COV_W-1:0];

    // restoring divider: first step compares the unshifted remainder (gain bit 32)
    assign div_t   = (r_cnt == '0) ? r_rem : {r_rem[RW-2:0], 1'b0};
    assign div_ge  = (div_t >= {1'b0, r_den});
    assign div_sub = div_t - {1'b0, r_den};

    assign diff_tgt  = (i_cmd.op == DP_DIV_INIT) ? x : r_est;
    assign diff_base = (i_cmd.op == DP_DIV_INIT) ? r_est : r_y;
    assign diff      = {diff_tgt[EW-1], diff_tgt} - {diff_base[EW-1], diff_base};
    assign diff_neg  = diff[MW-1];
    assign diff_mag  = diff_neg ? (MW'(0) - diff) : diff;

    always_comb begin
        mul_a = AW'(r_mag);
        mul_b = r_gain;
        case (i_cmd.op) inside
            DP_MUL_P_LO, DP_MUL_P_HI: begin
                mul_a = AW'(r_pp);
                mul_b = r_cgain;
            end
            DP_MUL_Y_LO, DP_MUL_Y_HI: begin
                mul_b = GAIN_W'(i_cfg.alpha);
            end
            default: begin
            end
        endcase
    end

    assign mul_hi = (i_cmd.op == DP_MUL_E_HI) || (i_cmd.op == DP_MUL_P_HI)
                 || (i_cmd.op == DP_MUL_Y_HI);
    assign b_part = mul_hi ? mul_b[GAIN_W-1:MUL_LO_W] : MUL_HI_W'(mul_b[MUL_LO_W-1:0]);
    assign prod   = PW'(mul_a) * PW'(b_part);

    // round half up on the magnitude, sign applied afterwards
    assign step_e  = r_acc[GAIN_SH +: MW] + MW'(r_acc[GAIN_SH-1]);
    assign step_y  = r_acc[ALPHA_SH +: MW] + MW'(r_acc[ALPHA_SH-1]);
    assign est_sum = r_neg ? ({r_est[EW-1], r_est} - step_e) : ({r_est[EW-1], r_est} + step_e);
    assign y_sum   = r_neg ? ({r_y[EW-1], r_y} - step_y) : ({r_y[EW-1], r_y} + step_y);
    assign p_next  = r_acc[GAIN_SH +: COV_W] + COV_W'(r_acc[GAIN_SH-1]);

    assign o_stat.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_y   <= '0;
            r_p   <= INIT_COV_RST;
            r_cnt <= '0;
        end else if (i_clr.clear) begin
            r_est <= '0;
            r_y   <= '0;
            r_p   <= i_clr.init;
        end else begin
            case (i_cmd.op)
                DP_DIV_INIT: r_cnt <= '0;
                DP_DIV_STEP: r_cnt <= r_cnt + CNT_W'(1);
                DP_UPD_E:    r_est <= est_sum[EW-1:0];
                DP_UPD_P:    r_p   <= p_next;
                DP_UPD_Y:    r_y   <= y_sum[EW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op) inside
            DP_CAPTURE: begin
                r_raw <= i_raw_sample;
                r_pp  <= pp_sat;
            end
            DP_DIV_INIT: begin
                r_den <= {1'b0, r_pp} + {1'b0, i_cfg.r};
                r_rem <= RW'(r_pp);
                r_q   <= '0;
                r_mag <= diff_mag;
                r_neg <= diff_neg;
            end
            DP_DIV_STEP: begin
                r_rem <= div_ge ? div_sub : div_t;
                r_q   <= {r_q[GAIN_W-2:0], div_ge};
            end
            DP_GAIN: begin
                r_gain <= (r_den == '0) ? '0 : r_q;
            end
            DP_MUL_E_LO, DP_MUL_P_LO, DP_MUL_Y_LO: begin
                r_acc <= ACC_W'(prod);
            end
            DP_MUL_E_HI, DP_MUL_P_HI, DP_MUL_Y_HI: begin
                r_acc <= r_acc + (ACC_W'(prod) << MUL_LO_W);
            end
            DP_UPD_E: begin
                r_cgain <= GAIN_ONE - r_gain;
            end
            DP_DIFF_Y: begin
                r_mag <= diff_mag;
                r_neg <= diff_neg;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            if (i_cfg.bypass) begin
                r_kal <= r_raw;
                r_smo <= r_raw;
            end else begin
                r_kal <= f_round_sat(r_est);
                r_smo <= f_round_sat(r_y);
            end
        end
    end

    assign o_kalman_value   = r_kal;
    assign o_smoothed_value = r_smo;

    `KLS_ASSERT_NEXT(a_rem_bound, i_cmd.op == DP_DIV_STEP, r_rem < {1'b0, r_den} || r_den == '0, "divider remainder not below divisor")
    `KLS_ASSERT_NEXT(a_gain_max, i_cmd.op == DP_GAIN, r_gain <= GAIN_ONE, "Kalman gain above one")
    `KLS_ASSERT_NEXT(a_cov_shrink, i_cmd.op == DP_UPD_P && !i_clr.clear, r_p <= $past(r_pp), "updated covariance above predicted covariance")

endmodule

@@ rtl/kalman_lowpass_smoother_top.sv @@
// Kalman estimate plus first-order low-pass, one result transaction per input transaction.
// Filter path: a 33-step restoring gain divider, then a shared two-slice multiplier for the
// estimate, covariance and low-pass updates. Bypass path: capture goes straight to the result.
// Input stalls while a transaction is in sequence. A waiting result does not block the next input.
// Synchronous active-low reset loads register defaults, zeroes estimate and low-pass,
// loads covariance from its initial value. Any valid config write does the same clear.
module kalman_lowpass_smoother_top
    import kls_pkg::*;
#(
    parameter int SAMPLE_BITS   = KLS_SAMPLE_BITS,
    parameter int FRACTION_BITS = KLS_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_raw_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_kalman_value,
    output logic signed [SAMPLE_BITS-1:0] o_smoothed_value,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata
);

    logic [COV_W-1:0]   r_q;
    logic [COV_W-1:0]   r_r;
    logic [COV_W-1:0]   r_init;
    logic [ALPHA_W-1:0] r_alpha;
    logic               r_bypass;

    logic  idx_valid;
    t_cfg  cfg;
    t_clr  clr;
    t_cmd  cmd;
    t_stat stat;

    always_comb begin
        idx_valid = 1'b0;
        clr.init  = r_init;
        unique case (i_cfg_index) inside
            CFG_PROCESS_NOISE, CFG_MEASUREMENT_NOISE,
            CFG_SMOOTHING_COEFFICIENT, CFG_BYPASS: begin
                idx_valid = 1'b1;
            end
            CFG_INITIAL_COVARIANCE: begin
                idx_valid = 1'b1;
                clr.init  = i_cfg_wdata[COV_W-1:0];
            end
            default: begin
                idx_valid = 1'b0;
            end
        endcase
        clr.clear = i_cfg_we && idx_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q      <= Q_RST;
            r_r      <= R_RST;
            r_init   <= INIT_COV_RST;
            r_alpha  <= ALPHA_RST;
            r_bypass <= BYPASS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE:         r_q      <= i_cfg_wdata[COV_W-1:0];
                CFG_MEASUREMENT_NOISE:     r_r      <= i_cfg_wdata[COV_W-1:0];
                CFG_INITIAL_COVARIANCE:    r_init   <= i_cfg_wdata[COV_W-1:0];
                CFG_SMOOTHING_COEFFICIENT: r_alpha  <= i_cfg_wdata[ALPHA_W-1:0];
                CFG_BYPASS:                r_bypass <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // alpha above one acts as one
    assign cfg.q      = r_q;
    assign cfg.r      = r_r;
    assign cfg.alpha  = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign cfg.bypass = r_bypass;

    kls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_bypass    (r_bypass),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kls_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg            (cfg),
        .i_clr            (clr),
        .i_raw_sample     (i_raw_sample),
        .o_kalman_value   (o_kalman_value),
        .o_smoothed_value (o_smoothed_value)
    );

endmodule

@@ test/kls_checker.sv @@
`timescale 1ns / 100ps

module kls_checker
    import kls_pkg::*;
#(
    parameter int SAMPLE_BITS   = KLS_SAMPLE_BITS,
    parameter int FRACTION_BITS = KLS_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_raw_sample,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_kalman_value,
    input  logic signed [SAMPLE_BITS-1:0] i_smoothed_value,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    output int                            o_error_count,
    output int                            o_pending
);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] kalman;
        logic signed [SAMPLE_BITS-1:0] smoothed;
    } t_filter_out;

    localparam longint      OUT_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint      OUT_MIN    = -OUT_MAX - 1;
    localparam logic [63:0] COV_FULL   = 64'hFFFF_FFFF;
    localparam logic [63:0] GAIN_UNITY = 64'd1 << GAIN_SH;

    // filter registers
    logic [COV_W-1:0]   process_noise;
    logic [COV_W-1:0]   meas_noise;
    logic [COV_W-1:0]   init_cov;
    logic [ALPHA_W-1:0] alpha;
    logic               bypass_mode;

    // filter state, estimate and low-pass in Q(SAMPLE_BITS).(FRACTION_BITS)
    longint             estimate;
    longint             lowpass;
    logic [COV_W-1:0]   error_cov;

    t_filter_out expected_outputs[$];
    int          error_count  = 0;
    int          result_count = 0;

    task automatic report_mismatch(input string msg);
        $display("kls_checker: %s", msg);
        error_count++;
    endtask

    task automatic restart_filter();
        estimate  = 0;
        lowpass   = 0;
        error_cov = init_cov;
    endtask

    // round half up of a*b / 2^sh, full-width product
    function automatic logic [63:0] scale_round(input logic [63:0] a, input logic [63:0] b,
                                                input int sh);
        logic [127:0] prod;
        prod = a * b;
        prod = prod + (128'd1 << (sh - 1));
        return 64'(prod >> sh);
    endfunction

    // rounding on the magnitude, so the step never overshoots the target
    function automatic longint move_toward(input longint pos, input longint target,
                                           input logic [63:0] coeff, input int sh);
        longint      diff;
        logic [63:0] mag;
        logic [63:0] step;
        diff = target - pos;
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        step = scale_round(mag, coeff, sh);
        return (diff < 0) ? pos - $signed(step) : pos + $signed(step);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        if (r > OUT_MAX)
            r = OUT_MAX;
        if (r < OUT_MIN)
            r = OUT_MIN;
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_filter_out predict_filter_output(
        input logic signed [SAMPLE_BITS-1:0] sample
    );
        t_filter_out res;
        logic [63:0] pp;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] a;
        longint      x;
        if (bypass_mode) begin
            res.kalman   = sample;
            res.smoothed = sample;
            return res;
        end
        x  = longint'(sample) * (longint'(1) <<< FRACTION_BITS);
        pp = 64'(error_cov) + 64'(process_noise);
        if (pp > COV_FULL)
            pp = COV_FULL;
        den  = pp + 64'(meas_noise);
        gain = (den != 0) ? (pp << GAIN_SH) / den : 64'd0;
        estimate  = move_toward(estimate, x, gain, GAIN_SH);
        error_cov = COV_W'(scale_round(GAIN_UNITY - gain, pp, GAIN_SH));
        a = (alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha);
        lowpass = move_toward(lowpass, estimate, a, ALPHA_SH);
        res.kalman   = round_saturate(estimate);
        res.smoothed = round_saturate(lowpass);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_filter_out want;
        if (!i_rst_n) begin
            process_noise = Q_RST;
            meas_noise    = R_RST;
            init_cov      = INIT_COV_RST;
            alpha         = ALPHA_RST;
            bypass_mode   = BYPASS_RST;
            restart_filter();
            expected_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE:         process_noise = i_cfg_wdata[COV_W-1:0];
                    CFG_MEASUREMENT_NOISE:     meas_noise    = i_cfg_wdata[COV_W-1:0];
                    CFG_INITIAL_COVARIANCE:    init_cov      = i_cfg_wdata[COV_W-1:0];
                    CFG_SMOOTHING_COEFFICIENT: alpha         = i_cfg_wdata[ALPHA_W-1:0];
                    CFG_BYPASS:                bypass_mode   = i_cfg_wdata[0];
                    default: ;
                endcase
                // unused indexes leave everything alone
                if (i_cfg_index <= CFG_BYPASS)
                    restart_filter();
            end
            if (i_in_valid && !i_in_stall)
                expected_outputs.push_back(predict_filter_output(i_raw_sample));
            if (i_out_valid && !i_out_stall) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d: kalman %0d smoothed %0d",
                                              result_count, i_kalman_value,
                                              i_smoothed_value));
                end else begin
                    want = expected_outputs.pop_front();
                    if (i_kalman_value !== want.kalman)
                        report_mismatch($sformatf("result %0d: kalman_value %0d, expected %0d",
                                                  result_count, i_kalman_value, want.kalman));
                    if (i_smoothed_value !== want.smoothed)
                        report_mismatch($sformatf(
                            "result %0d: smoothed_value %0d, expected %0d",
                            result_count, i_smoothed_value, want.smoothed));
                end
                result_count++;
            end
        end
        o_error_count <= error_count;
        o_pending     <= expected_outputs.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
    import kls_pkg::*;
();

    localparam int SB             = KLS_SAMPLE_BITS;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 185;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int CYCLE_LIMIT    = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_BYPASS + 1);
    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB - 1){1'b0}}};

    typedef enum {
        SAMPLES_UNIFORM,
        SAMPLES_WALK,
        SAMPLES_EXTREME,
        SAMPLES_NOISY_LEVEL
    } t_sample_style;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic signed [SB-1:0]  raw       = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [SB-1:0]  kalman_value;
    logic signed [SB-1:0]  smoothed_value;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int error_count;
    int pending;
    int cycle_count = 0;
    int holds_asked = 0;
    bit idle_on     = 1'b1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    kalman_lowpass_smoother_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_raw_sample     (raw),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_kalman_value   (kalman_value),
        .o_smoothed_value (smoothed_value),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata)
    );

    kls_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_raw_sample     (raw),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_kalman_value   (kalman_value),
        .i_smoothed_value (smoothed_value),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .o_error_count    (error_count),
        .o_pending        (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_len();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_covariance();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return $urandom_range(0, 1 << 20);
            4:       return CFG_DATA_W'(1) << $urandom_range(0, COV_W - 1);
            default: return $urandom_range(100000, 100000000);
        endcase
    endfunction

    function automatic logic signed [SB-1:0] next_sample(input t_sample_style style,
                                                         input logic signed [SB-1:0] prev);
        case (style)
            SAMPLES_UNIFORM:
                return SB'($urandom);
            SAMPLES_WALK:
                return SB'(int'(prev) + int'($urandom_range(0, 512)) - 256);
            SAMPLES_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return '0;
                    default: return prev;
                endcase
            default: begin
                // occasional level jump, otherwise small noise around it
                if ($urandom_range(0, 15) == 0)
                    return SB'($urandom);
                return SB'(int'(prev) + int'($urandom_range(0, 31)) - 16);
            end
        endcase
    endfunction

    // leaves valid high after the transaction so back-to-back items need no second update
    task automatic send_sample(input logic signed [SB-1:0] value);
        int gap;
        gap = pick_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw      <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // only once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0 || in_stall);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // result side backpressure
    initial begin
        int run_left;
        int hold_left;
        int holds_served;
        bit stall_run;
        run_left     = 0;
        hold_left    = 0;
        holds_served = 0;
        stall_run    = 1'b0;
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stall_run = idle_on && ($urandom_range(0, 2) == 0);
                    run_left  = stall_run ? pick_len() : $urandom_range(1, 24);
                    if (run_left == 0)
                        run_left = 1;
                end
                out_stall <= stall_run;
                run_left--;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        logic signed [SB-1:0]  prev;
        logic [CFG_DATA_W-1:0] value;
        t_sample_style         style;
        int                    first_reg;
        prev  = '0;
        style = SAMPLES_UNIFORM;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: steps between the rails
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(SB'(-1));
        send_sample(SB'(1));
        send_sample(SB'(16'h5555));
        send_sample(SB'(16'hAAAA));

        // writes to unused indexes must not disturb the running filter
        for (int k = CFG_FIRST_UNUSED; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), $urandom);
        send_sample(SB'($urandom));
        send_sample(SB'($urandom));

        // no measurement noise: gain of one
        write_reg(CFG_MEASUREMENT_NOISE, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SB'($urandom));

        // all covariances zero: zero denominator, estimate holds
        write_reg(CFG_PROCESS_NOISE, '0);
        write_reg(CFG_INITIAL_COVARIANCE, '0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);

        // covariances at full scale, alpha above one
        write_reg(CFG_PROCESS_NOISE, '1);
        write_reg(CFG_MEASUREMENT_NOISE, '1);
        write_reg(CFG_INITIAL_COVARIANCE, '1);
        write_reg(CFG_SMOOTHING_COEFFICIENT, '1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);

        // frozen low-pass
        write_reg(CFG_SMOOTHING_COEFFICIENT, '0);
        send_sample(SAMPLE_MIN);
        send_sample(SB'($urandom));

        write_reg(CFG_BYPASS, '1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SB'($urandom));
        write_reg(CFG_BYPASS, '0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // the long-hold phase and every third phase run with no gaps and no random stalls
            idle_on = (ph % 3) != 2 && ph != 1;
            first_reg = $urandom_range(0, CFG_BYPASS);
            for (int j = 0; j <= CFG_BYPASS; j++) begin
                case ((first_reg + j) % (CFG_BYPASS + 1))
                    CFG_PROCESS_NOISE:
                        write_reg(CFG_PROCESS_NOISE, pick_covariance());
                    CFG_MEASUREMENT_NOISE:
                        write_reg(CFG_MEASUREMENT_NOISE, pick_covariance());
                    CFG_INITIAL_COVARIANCE:
                        write_reg(CFG_INITIAL_COVARIANCE, pick_covariance());
                    CFG_SMOOTHING_COEFFICIENT: begin
                        case ($urandom_range(0, 4))
                            0:       value = '0;
                            1:       value = CFG_DATA_W'(ALPHA_ONE);
                            2:       value = $urandom_range(1, ALPHA_ONE - 1);
                            3:       value = $urandom;
                            default: value = $urandom_range(30000, ALPHA_ONE - 1);
                        endcase
                        write_reg(CFG_SMOOTHING_COEFFICIENT, value);
                    end
                    default: begin
                        value    = $urandom;
                        value[0] = ($urandom_range(0, 4) == 0);
                        write_reg(CFG_BYPASS, value);
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), $urandom);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0)
                    style = t_sample_style'($urandom_range(0, 3));
                // long result hold-off while items keep coming, so the input backs up
                if (ph == 1 && n == 30)
                    holds_asked++;
                prev = next_sample(style, prev);
                send_sample(prev);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
